// ===== hw/rtl/lmts_pkg.sv =====
// Shared types, codes and the pattern generator step for the memory test sequencer.
`default_nettype none

package lmts_pkg;

    // Widest address the sequencer supports; addresses are widened to this before slicing.
    localparam int ADDR_BITS_MAX = 48;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST_WORD_INDEX  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_WORDS      = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHECK_LAG_BLOCKS = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [31:0] LAST_WORD_INDEX_RESET  = 32'd134217727;
    localparam logic [16:0] BLOCK_WORDS_RESET      = 17'd16384;
    localparam logic [7:0]  CHECK_LAG_BLOCKS_RESET = 8'd16;

    // Access kinds on the result.
    localparam logic [1:0] ACCESS_NONE  = 2'd0;
    localparam logic [1:0] ACCESS_WRITE = 2'd1;
    localparam logic [1:0] ACCESS_READ  = 2'd2;

    // Request modes.
    localparam logic MODE_ACCESS = 1'b0;
    localparam logic MODE_RETURN = 1'b1;

    typedef struct packed {
        logic [31:0] last_word_index;
        logic [16:0] block_words;
        logic [7:0]  check_lag_blocks;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  access_kind;
        logic [31:0] word_address;
        logic [63:0] write_data;
        logic [63:0] expected_data;
        logic        mismatch;
        logic        stopped;
    } result_t;

    // One step of the 64-bit LFSR: taps 64, 63, 61, 60 with an inverted feedback,
    // shifted in at the top while the word moves right.
    function automatic logic [63:0] next_pattern(input logic [63:0] d);
        logic fb;
        fb = ~(d[0] ^ d[1] ^ d[3] ^ d[4]);
        return {fb, d[63:1]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lmts_core.sv =====
// Sequencer state and the combinational decision logic for one request.
`default_nettype none

module lmts_core
    import lmts_pkg::*;
#(
    parameter int ADDR_BITS = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic        mode,
    input  wire logic [63:0] read_data,
    input  wire cfg_t        cfg,
    output result_t          result
);

    logic [ADDR_BITS-1:0] write_address_reg, write_address_next;
    logic [ADDR_BITS-1:0] read_address_reg, read_address_next;
    logic [63:0]          write_pattern_reg, write_pattern_next;
    logic [63:0]          read_pattern_reg, read_pattern_next;
    logic [16:0]          words_in_block_reg, words_in_block_next;
    logic [7:0]           blocks_ahead_reg, blocks_ahead_next;
    logic                 checking_phase_reg, checking_phase_next;
    logic                 read_pending_reg, read_pending_next;
    logic                 halted_reg, halted_next;

    logic [ADDR_BITS_MAX-1:0] limit_wide;
    logic [ADDR_BITS-1:0]     addr_limit;
    logic [ADDR_BITS_MAX-1:0] write_addr_wide;
    logic [ADDR_BITS_MAX-1:0] read_addr_wide;
    logic [ADDR_BITS-1:0]     write_addr_step;
    logic [ADDR_BITS-1:0]     read_addr_step;
    logic [16:0]              block_limit;
    logic [16:0]              words_inc;
    logic                     block_end;
    logic [7:0]               blocks_ahead_inc;

    always_comb
    begin
        limit_wide      = ADDR_BITS_MAX'(cfg.last_word_index);
        addr_limit      = limit_wide[ADDR_BITS-1:0];
        write_addr_wide = ADDR_BITS_MAX'(write_address_reg);
        read_addr_wide  = ADDR_BITS_MAX'(read_address_reg);
        write_addr_step = (write_address_reg == addr_limit) ? '0 : write_address_reg + 1'b1;
        read_addr_step  = (read_address_reg == addr_limit) ? '0 : read_address_reg + 1'b1;
        // A block size of zero behaves as one word.
        block_limit     = (cfg.block_words == '0) ? 17'd1 : cfg.block_words;
        words_inc       = words_in_block_reg + 17'd1;
        block_end       = (words_inc >= block_limit);
    end

    always_comb
    begin
        write_address_next  = write_address_reg;
        read_address_next   = read_address_reg;
        write_pattern_next  = write_pattern_reg;
        read_pattern_next   = read_pattern_reg;
        words_in_block_next = words_in_block_reg;
        blocks_ahead_next   = blocks_ahead_reg;
        checking_phase_next = checking_phase_reg;
        read_pending_next   = read_pending_reg;
        halted_next         = halted_reg;
        blocks_ahead_inc    = blocks_ahead_reg;
        result              = '0;

        if (halted_reg)
        begin
            result.stopped = 1'b1;
        end
        else if (mode == MODE_ACCESS)
        begin
            // An access request while a read is outstanding stalls with an empty result.
            if (!read_pending_reg)
            begin
                if (!checking_phase_reg)
                begin
                    result.access_kind  = ACCESS_WRITE;
                    result.word_address = write_addr_wide[31:0];
                    result.write_data   = write_pattern_reg;
                    write_address_next  = write_addr_step;
                    write_pattern_next  = next_pattern(write_pattern_reg);
                    words_in_block_next = block_end ? '0 : words_inc;
                    if (block_end)
                    begin
                        if (blocks_ahead_reg < cfg.check_lag_blocks)
                        begin
                            blocks_ahead_inc = blocks_ahead_reg + 8'd1;
                        end
                        blocks_ahead_next = blocks_ahead_inc;
                        if (blocks_ahead_inc == cfg.check_lag_blocks)
                        begin
                            checking_phase_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    result.access_kind  = ACCESS_READ;
                    result.word_address = read_addr_wide[31:0];
                    read_pending_next   = 1'b1;
                end
            end
        end
        else if (read_pending_reg)
        begin
            read_pending_next    = 1'b0;
            result.word_address  = read_addr_wide[31:0];
            result.expected_data = read_pattern_reg;
            if (read_data != read_pattern_reg)
            begin
                result.mismatch = 1'b1;
                result.stopped  = 1'b1;
                halted_next     = 1'b1;
            end
            else
            begin
                read_address_next   = read_addr_step;
                read_pattern_next   = next_pattern(read_pattern_reg);
                words_in_block_next = block_end ? '0 : words_inc;
                if (block_end)
                begin
                    checking_phase_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_address_reg  <= '0;
            read_address_reg   <= '0;
            write_pattern_reg  <= '0;
            read_pattern_reg   <= '0;
            words_in_block_reg <= '0;
            blocks_ahead_reg   <= '0;
            checking_phase_reg <= 1'b0;
            read_pending_reg   <= 1'b0;
            halted_reg         <= 1'b0;
        end
        else if (fire)
        begin
            write_address_reg  <= write_address_next;
            read_address_reg   <= read_address_next;
            write_pattern_reg  <= write_pattern_next;
            read_pattern_reg   <= read_pattern_next;
            words_in_block_reg <= words_in_block_next;
            blocks_ahead_reg   <= blocks_ahead_next;
            checking_phase_reg <= checking_phase_next;
            read_pending_reg   <= read_pending_next;
            halted_reg         <= halted_next;
        end
    end

    // A read can only be outstanding during a check block.
    a_pending_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        read_pending_reg |-> checking_phase_reg)
        else $error("read outstanding outside a check block");

    // Once halted, the sequencer never leaves that state.
    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> halted_reg)
        else $error("halt state was left without reset");

    // A halted sequencer issues no commands and moves no pattern.
    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && halted_reg) |=> ($stable(write_pattern_reg) && $stable(read_pattern_reg)))
        else $error("pattern moved while halted");

    // A mismatch always halts and never comes with a command.
    a_mismatch_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.mismatch) |=> (halted_reg && !read_pending_reg))
        else $error("mismatch did not halt the test");

endmodule

`default_nettype wire

// ===== hw/rtl/lfsr_memory_test_sequencer_top.sv =====
// Top level of the LFSR memory test sequencer: request and result registers, configuration.
`default_nettype none

// The sequencer drives a memory self-test. Each request with mode 0 asks for the next
// memory access: during a write block it answers with a write command carrying the next
// word of a 64-bit LFSR pattern, during a check block with a read command. A request with
// mode 1 delivers the data returned for that read, which is compared with a second copy of
// the pattern; the result shows the address, the expected word and whether it matched.
// The first mismatch halts the test until reset, and every later request answers with
// stopped set. Checking starts once check_lag_blocks write blocks are ahead, after which
// write and check blocks alternate. Every request produces exactly one result. A request
// is registered on acceptance and its result is registered when the request moves on,
// which waits while a finished result is held back; one request is taken in every cycle
// while results are being drained, the throughput being set by the combinational pattern
// step, address wrap and compare in the core. The input stalls only
// while a finished result is held back by the output side and another request is waiting
// behind it. Configuration writes are taken at any time but should be made while the
// block is idle.
module lfsr_memory_test_sequencer_top
    import lmts_pkg::*;
#(
    parameter int ADDR_BITS = 32
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      cfg_write_enable,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,

    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      mode,
    input  wire logic [63:0]               read_data,

    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [1:0]                     access_kind,
    output logic [31:0]                    word_address,
    output logic [63:0]                    write_data,
    output logic [63:0]                    expected_data,
    output logic                           mismatch,
    output logic                           stopped
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic        mode_reg;
    logic [63:0] read_data_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     core_result;
    logic        fire;

    // The held request moves into the result register unless a finished result is stuck.
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;
    assign fire     = in_valid_reg && !in_stall;

    // Configuration registers; writes to an unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.last_word_index  <= LAST_WORD_INDEX_RESET;
            cfg_reg.block_words      <= BLOCK_WORDS_RESET;
            cfg_reg.check_lag_blocks <= CHECK_LAG_BLOCKS_RESET;
        end
        else if (cfg_write_enable)
        begin
            unique case (cfg_index)
                CFG_LAST_WORD_INDEX:  cfg_reg.last_word_index  <= cfg_data;
                CFG_BLOCK_WORDS:      cfg_reg.block_words      <= cfg_data[16:0];
                CFG_CHECK_LAG_BLOCKS: cfg_reg.check_lag_blocks <= cfg_data[7:0];
                default:              ;
            endcase
        end
    end

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            mode_reg      <= mode;
            read_data_reg <= read_data;
        end
    end

    lmts_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .mode      (mode_reg),
        .read_data (read_data_reg),
        .cfg       (cfg_reg),
        .result    (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign access_kind   = result_reg.access_kind;
    assign word_address  = result_reg.word_address;
    assign write_data    = result_reg.write_data;
    assign expected_data = result_reg.expected_data;
    assign mismatch      = result_reg.mismatch;
    assign stopped       = result_reg.stopped;

    // A request that is held with a free output must reach the result register.
    a_request_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held request did not produce a result");

    // A taken result with nothing behind it leaves the output empty.
    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !in_valid_reg) |=> !out_valid_reg)
        else $error("result repeated after it was taken");

    // A result held back by the output side stays valid and unchanged.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(result_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
